// ----- rtl/erd_pkg.sv -----
package erd_pkg;

  localparam int unsigned DATA_W     = 8;
  localparam int unsigned FLEN_W     = 16;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned LEN_BITS_D = 16;

  localparam logic [DATA_W-1:0] ESC_LO = 8'h00;
  localparam logic [DATA_W-1:0] ESC_HI = 8'hFF;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_DONE     = 3'd1,
    ST_OVERSIZE = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_NOCOUNT  = 3'd4,
    ST_SHORT    = 3'd5
  } status_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              first;
    logic [FLEN_W-1:0] compressed_len;
    logic [FLEN_W-1:0] expected_len;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] repeat_res;
    status_t           status;
    logic              last;
  } res_t;

endpackage

// ----- rtl/erd_dec.sv -----
module erd_dec #(
  parameter int unsigned LEN_BITS = erd_pkg::LEN_BITS_D
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  erd_pkg::item_t item,
  output logic           has_res,
  output erd_pkg::res_t  res
);

  logic                        raw_mode_r, raw_mode_nxt;
  logic                        await_r, await_nxt;
  logic [erd_pkg::DATA_W-1:0]  esc_r, esc_nxt;
  logic [LEN_BITS-1:0]         inl_r, inl_nxt;
  logic [LEN_BITS-1:0]         outl_r, outl_nxt;
  logic                        stopped_r, stopped_nxt;

  logic [LEN_BITS-1:0]         clen_w, elen_w;
  logic [LEN_BITS-1:0]         b_ext;
  logic [LEN_BITS-1:0]         il_dec;
  logic [LEN_BITS-1:0]         ol_sub;
  logic                        go;
  logic [erd_pkg::DATA_W-1:0]  b;

  generate
    if (LEN_BITS >= erd_pkg::FLEN_W) begin : g_wide
      assign clen_w = LEN_BITS'(item.compressed_len);
      assign elen_w = LEN_BITS'(item.expected_len);
    end else begin : g_narrow
      assign clen_w = item.compressed_len[LEN_BITS-1:0];
      assign elen_w = item.expected_len[LEN_BITS-1:0];
    end
  endgenerate

  assign b     = item.data_byte;
  assign b_ext = LEN_BITS'(b);

  always_comb begin
    raw_mode_nxt   = raw_mode_r;
    await_nxt      = await_r;
    esc_nxt        = esc_r;
    inl_nxt        = inl_r;
    outl_nxt       = outl_r;
    stopped_nxt    = stopped_r;
    has_res        = 1'b0;
    res.value      = '0;
    res.repeat_res = '0;
    res.status     = erd_pkg::ST_OK;
    go             = 1'b0;
    il_dec         = '0;
    ol_sub         = '0;

    if (item.first) begin
      stopped_nxt  = 1'b0;
      await_nxt    = 1'b0;
      esc_nxt      = '0;
      inl_nxt      = clen_w;
      outl_nxt     = elen_w;
      raw_mode_nxt = (clen_w == elen_w);
      if (clen_w > elen_w) begin
        has_res    = 1'b1;
        res.status = erd_pkg::ST_OVERSIZE;
      end else if (clen_w == '0) begin
        has_res    = 1'b1;
        res.status = (elen_w == '0) ? erd_pkg::ST_DONE : erd_pkg::ST_SHORT;
      end else begin
        go = 1'b1;
      end
    end else if (!stopped_r) begin
      go = 1'b1;
    end

    if (go) begin
      il_dec  = inl_nxt - LEN_BITS'(1);
      inl_nxt = il_dec;
      has_res = 1'b1;
      if (raw_mode_nxt) begin
        outl_nxt       = outl_nxt - LEN_BITS'(1);
        res.value      = b;
        res.repeat_res = erd_pkg::DATA_W'(1);
        res.status     = (il_dec == '0) ? erd_pkg::ST_DONE : erd_pkg::ST_OK;
      end else if (await_nxt) begin
        await_nxt = 1'b0;
        res.value = esc_nxt;
        if (b_ext > outl_nxt) begin
          res.repeat_res = outl_nxt[erd_pkg::DATA_W-1:0];
          res.status     = erd_pkg::ST_OVERFLOW;
        end else begin
          ol_sub         = outl_nxt - b_ext;
          outl_nxt       = ol_sub;
          res.repeat_res = b;
          if (il_dec != '0) begin
            res.status = erd_pkg::ST_OK;
          end else begin
            res.status = (ol_sub == '0) ? erd_pkg::ST_DONE : erd_pkg::ST_SHORT;
          end
        end
      end else if (outl_nxt == '0) begin
        res.value  = b;
        res.status = erd_pkg::ST_OVERFLOW;
      end else begin
        ol_sub         = outl_nxt - LEN_BITS'(1);
        outl_nxt       = ol_sub;
        res.value      = b;
        res.repeat_res = erd_pkg::DATA_W'(1);
        if (b == erd_pkg::ESC_LO || b == erd_pkg::ESC_HI) begin
          if (il_dec == '0) begin
            res.status = erd_pkg::ST_NOCOUNT;
          end else begin
            await_nxt  = 1'b1;
            esc_nxt    = b;
            res.status = erd_pkg::ST_OK;
          end
        end else if (il_dec != '0) begin
          res.status = erd_pkg::ST_OK;
        end else begin
          res.status = (ol_sub == '0) ? erd_pkg::ST_DONE : erd_pkg::ST_SHORT;
        end
      end
    end

    res.last = has_res && (res.status != erd_pkg::ST_OK);
    if (res.last) begin
      stopped_nxt = 1'b1;
      await_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_mode_r <= 1'b0;
      await_r    <= 1'b0;
      esc_r      <= '0;
      inl_r      <= '0;
      outl_r     <= '0;
      stopped_r  <= 1'b1;
    end else if (fire) begin
      raw_mode_r <= raw_mode_nxt;
      await_r    <= await_nxt;
      esc_r      <= esc_nxt;
      inl_r      <= inl_nxt;
      outl_r     <= outl_nxt;
      stopped_r  <= stopped_nxt;
    end
  end

  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && stopped_r && !item.first) |-> !has_res)
    else $error("result from a stopped block");

  a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && has_res && res.last) |=> (stopped_r && !await_r))
    else $error("block not stopped after final result");

  a_await_not_raw: assert property (@(posedge clk) disable iff (!rst_n)
    await_r |-> (!raw_mode_r && !stopped_r))
    else $error("count pending in raw or stopped block");

  a_esc_code: assert property (@(posedge clk) disable iff (!rst_n)
    await_r |-> (esc_r == erd_pkg::ESC_LO || esc_r == erd_pkg::ESC_HI))
    else $error("pending escape value is not an escape code");

endmodule

// ----- rtl/escape_rle_decoder.sv -----
// Escape run-length decoder. One compressed byte is taken per cycle while
// in_stall is low; a transaction with in_first high also loads the
// compressed and expected lengths and starts a block. Each byte yields at
// most one result: the byte value, the number of copies to write, a status
// and a last flag that marks the end of a block (done or any error). Runs
// behind 0x00 or 0xFF are reported as a count, not expanded. Bytes arriving
// after a block has ended are dropped until the next in_first. Throughput
// is one byte per cycle while out_stall is low, set by the single per-byte
// update of the decoder state; a byte passes the input register, then the
// result register, which drives out_valid. A stalled result holds the input
// register; in_stall rises once both are full and out_stall is high.
module escape_rle_decoder #(
  parameter int unsigned LEN_BITS = erd_pkg::LEN_BITS_D
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [erd_pkg::DATA_W-1:0]    in_data_byte,
  input  logic                          in_first,
  input  logic [erd_pkg::FLEN_W-1:0]    in_compressed_len,
  input  logic [erd_pkg::FLEN_W-1:0]    in_expected_len,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [erd_pkg::DATA_W-1:0]    out_value,
  output logic [erd_pkg::DATA_W-1:0]    out_repeat_res,
  output logic [erd_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_last
);

  logic           in_vld_r;
  erd_pkg::item_t item_r;
  logic           out_vld_r;
  erd_pkg::res_t  res_r;
  logic           adv;
  logic           in_acc;
  logic           has_res;
  erd_pkg::res_t  res;

  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.data_byte      <= in_data_byte;
      item_r.first          <= in_first;
      item_r.compressed_len <= in_compressed_len;
      item_r.expected_len   <= in_expected_len;
    end
  end

  erd_dec #(
    .LEN_BITS(LEN_BITS)
  ) u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (adv),
    .item    (item_r),
    .has_res (has_res),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= has_res;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && has_res) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_value      = res_r.value;
  assign out_repeat_res = res_r.repeat_res;
  assign out_status     = res_r.status;
  assign out_last       = res_r.last;

endmodule

// ----- dv/rle_check_pkg.sv -----
package rle_check_pkg;

  import erd_pkg::*;

  class run_scoreboard;

    bit raw_mode;
    bit await_count;
    bit stopped;
    logic [7:0] esc_byte;
    logic [15:0] in_left;
    logic [15:0] out_left;

    res_t expected_runs[$];

    int consumed;
    int runs_seen;
    int errors;
    int block_ends[6];

    function new();
      raw_mode = 1'b0;
      await_count = 1'b0;
      stopped = 1'b1;
      esc_byte = '0;
      in_left = '0;
      out_left = '0;
      consumed = 0;
      runs_seen = 0;
      errors = 0;
      foreach (block_ends[i]) block_ends[i] = 0;
    endfunction

    function status_t end_code();
      return (out_left == 0) ? ST_DONE : ST_SHORT;
    endfunction

    function void queue_run(logic [7:0] v, logic [7:0] r, status_t st);
      res_t e;
      e.value = v;
      e.repeat_res = r;
      e.status = st;
      e.last = (st != ST_OK);
      if (e.last) begin
        stopped = 1'b1;
        await_count = 1'b0;
      end
      expected_runs.push_back(e);
    endfunction

    // Predict the run caused by one accepted byte transaction.
    function void note_byte(logic [7:0] b, logic first, logic [15:0] clen,
                            logic [15:0] elen);
      if (first) begin
        stopped = 1'b0;
        await_count = 1'b0;
        esc_byte = '0;
        in_left = clen;
        out_left = elen;
        raw_mode = (clen == elen);
        consumed++;
        if (clen > elen) begin
          queue_run(8'h00, 8'h00, ST_OVERSIZE);
          return;
        end
        if (clen == 0) begin
          queue_run(8'h00, 8'h00, end_code());
          return;
        end
      end else if (stopped) begin
        return;
      end else begin
        consumed++;
      end

      in_left = in_left - 16'd1;

      if (raw_mode) begin
        out_left = out_left - 16'd1;
        queue_run(b, 8'd1, (in_left == 0) ? ST_DONE : ST_OK);
        return;
      end

      if (await_count) begin
        await_count = 1'b0;
        if (16'(b) > out_left) begin
          queue_run(esc_byte, out_left[7:0], ST_OVERFLOW);
          return;
        end
        out_left = out_left - 16'(b);
        queue_run(esc_byte, b, (in_left == 0) ? end_code() : ST_OK);
        return;
      end

      if (out_left == 0) begin
        queue_run(b, 8'd0, ST_OVERFLOW);
        return;
      end
      out_left = out_left - 16'd1;

      if (b == ESC_LO || b == ESC_HI) begin
        if (in_left == 0) begin
          queue_run(b, 8'd1, ST_NOCOUNT);
          return;
        end
        await_count = 1'b1;
        esc_byte = b;
        queue_run(b, 8'd1, ST_OK);
        return;
      end

      queue_run(b, 8'd1, (in_left == 0) ? end_code() : ST_OK);
    endfunction

    function void check_run(logic [7:0] value, logic [7:0] rep, logic [2:0] st,
                            logic last);
      res_t e;
      runs_seen++;
      if (expected_runs.size() == 0) begin
        errors++;
        $display("%0t: unexpected run, expected none, actual value %0h repeat %0d status %0d last %0b",
                 $time, value, rep, st, last);
        return;
      end
      e = expected_runs.pop_front();
      if (value !== e.value) begin
        errors++;
        $display("%0t: out_value expected %0h, actual %0h", $time, e.value, value);
      end
      if (rep !== e.repeat_res) begin
        errors++;
        $display("%0t: out_repeat_res expected %0d, actual %0d", $time, e.repeat_res, rep);
      end
      if (st !== e.status) begin
        errors++;
        $display("%0t: out_status expected %0d, actual %0d", $time, e.status, st);
      end
      if (last !== e.last) begin
        errors++;
        $display("%0t: out_last expected %0b, actual %0b", $time, e.last, last);
      end
      if (e.last) block_ends[int'(e.status)]++;
    endfunction

  endclass

endpackage

// ----- dv/tb.sv -----
module tb;

  import erd_pkg::*;
  import rle_check_pkg::*;

  localparam int ITEMS = 1750;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_data_byte = '0;
  logic in_first = 1'b0;
  logic [15:0] in_compressed_len = '0;
  logic [15:0] in_expected_len = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_value;
  logic [7:0] out_repeat_res;
  logic [2:0] out_status;
  logic out_last;

  bit calm = 1'b0;
  bit gappy = 1'b0;
  bit hold_off = 1'b0;
  bit hold_done = 1'b0;

  run_scoreboard sb = new();

  escape_rle_decoder uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_first         (in_first),
    .in_compressed_len(in_compressed_len),
    .in_expected_len  (in_expected_len),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_value        (out_value),
    .out_repeat_res   (out_repeat_res),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_byte(in_data_byte, in_first, in_compressed_len, in_expected_len);
    end
    if (rst_n && out_valid && !out_stall) begin
      sb.check_run(out_value, out_repeat_res, out_status, out_last);
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off, none once calm.
  initial begin : receiver
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat (calm ? 1 : $urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic f, logic [15:0] clen, logic [15:0] elen);
    if (gappy && !calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_first <= f;
    in_compressed_len <= clen;
    in_expected_len <= elen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_block(logic [15:0] clen, logic [15:0] elen, input logic [7:0] q[$]);
    if (q.size() == 0) begin
      send_byte(8'($urandom_range(0, 255)), 1'b1, clen, elen);
    end else begin
      foreach (q[i]) begin
        if (i == 0) send_byte(q[i], 1'b1, clen, elen);
        else send_byte(q[i], 1'b0, 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)));
      end
    end
  endtask

  task automatic send_noise(int n);
    repeat (n) begin
      send_byte(8'($urandom_range(0, 255)), 1'b0, 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)));
    end
  endtask

  task automatic random_block();
    logic [7:0] q[$];
    logic [7:0] esc;
    int kind;
    int produced;
    int cnt;
    int clen;
    int elen;
    int k;
    kind = $urandom_range(0, 99);
    gappy = ($urandom_range(0, 2) != 0);
    produced = 0;
    if (kind < 65) begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 2) == 0) begin
          esc = $urandom_range(0, 1) ? ESC_HI : ESC_LO;
          cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
          q.push_back(esc);
          q.push_back(cnt[7:0]);
          produced += 1 + cnt;
        end else begin
          q.push_back(8'($urandom_range(1, 254)));
          produced++;
        end
      end
      while (produced <= q.size()) begin
        cnt = $urandom_range(2, 20);
        q.push_back($urandom_range(0, 1) ? ESC_HI : ESC_LO);
        q.push_back(cnt[7:0]);
        produced += 1 + cnt;
      end
      if ($urandom_range(0, 9) == 0) begin
        q.push_back($urandom_range(0, 1) ? ESC_HI : ESC_LO);
        produced++;
      end
      clen = q.size();
      k = $urandom_range(0, 9);
      if (k == 0) elen = produced + $urandom_range(1, 40);
      else if (k == 1) elen = (produced - $urandom_range(1, 20) > clen) ?
                              produced - $urandom_range(1, 20) : clen + 1;
      else elen = produced;
      send_block(16'(clen), 16'(elen), q);
      if ($urandom_range(0, 9) == 0) send_noise($urandom_range(1, 3));
    end else if (kind < 75) begin
      repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
      send_block(16'(q.size()), 16'(q.size()), q);
    end else if (kind < 80) begin
      send_block(16'd0, $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 65535)), q);
    end else if (kind < 85) begin
      elen = $urandom_range(0, 65534);
      clen = $urandom_range(elen + 1, 65535);
      send_block(16'(clen), 16'(elen), q);
      send_noise($urandom_range(0, 3));
    end else if (kind < 92) begin
      // abandon the block partway; the next first restarts it
      repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
      clen = q.size() + $urandom_range(1, 10);
      send_block(16'(clen), 16'(clen + $urandom_range(1, 50)), q);
    end else if (kind < 97) begin
      send_noise($urandom_range(1, 4));
    end else begin
      repeat ($urandom_range(0, 4)) q.push_back(8'($urandom_range(0, 255)));
      send_block(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), q);
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_byte(8'hFF, 1'b1, 16'd0, 16'd0);
    send_byte(8'h00, 1'b1, 16'd0, 16'hFFFF);
    send_byte(8'hA5, 1'b1, 16'hFFFF, 16'hFFFE);
    send_byte(8'h3C, 1'b0, 16'h5A5A, 16'hA5A5);
    send_byte(8'h00, 1'b1, 16'd2, 16'd2);
    send_byte(8'hFF, 1'b0, 16'd0, 16'd0);
    send_byte(8'hFF, 1'b1, 16'd3, 16'd257);
    send_byte(8'hFF, 1'b0, 16'hFFFF, 16'hFFFF);
    send_byte(8'h01, 1'b0, 16'd0, 16'd0);
    send_byte(8'h00, 1'b1, 16'd1, 16'd5);
    send_byte(8'h00, 1'b1, 16'd2, 16'd4);
    send_byte(8'd200, 1'b0, 16'd0, 16'd0);
    send_byte(8'hFF, 1'b1, 16'd4, 16'd5);
    send_byte(8'h04, 1'b0, 16'd0, 16'd0);
    send_byte(8'h12, 1'b0, 16'd0, 16'd0);
    send_byte(8'h34, 1'b0, 16'd0, 16'd0);
    send_byte(8'h80, 1'b1, 16'd1, 16'd9);
    send_byte(8'h55, 1'b1, 16'hFFFF, 16'hFFFF);
    send_byte(8'hFE, 1'b0, 16'd0, 16'd0);
    send_byte(8'h00, 1'b1, 16'd4, 16'd7);
    send_byte(8'h00, 1'b0, 16'd0, 16'd0);
    send_byte(8'hFF, 1'b0, 16'd0, 16'd0);
    send_byte(8'h05, 1'b0, 16'd0, 16'd0);
    send_byte(8'h7F, 1'b1, 16'd2, 16'd40);

    while (sb.consumed < ITEMS) begin
      if (!hold_done && sb.consumed >= 700) begin
        hold_done = 1'b1;
        hold_off = 1'b1;
      end
      if (sb.consumed >= ITEMS - 200) calm = 1'b1;
      random_block();
    end
    in_valid <= 1'b0;

    while (sb.expected_runs.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Decoded %0d bytes into %0d runs, %0d mismatches.",
             sb.consumed, sb.runs_seen, sb.errors);
    $display("Block ends: done %0d, oversize %0d, overflow %0d, missing count %0d, short %0d.",
             sb.block_ends[ST_DONE], sb.block_ends[ST_OVERSIZE],
             sb.block_ends[ST_OVERFLOW], sb.block_ends[ST_NOCOUNT],
             sb.block_ends[ST_SHORT]);
    if (sb.errors == 0 && sb.expected_runs.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/erd_pkg.sv
rtl/erd_dec.sv
rtl/escape_rle_decoder.sv
dv/rle_check_pkg.sv
dv/tb.sv
